// ===== src/svf2x_pkg.sv =====
// ----------------------------------------------------------------------------
// svf2x_pkg: shared types, constants and a function
// Word layout, datapath command and status, mode codes and a saturation helper
// for the double-sampled state variable filter.
// ----------------------------------------------------------------------------
package svf2x_pkg;

    localparam int SAMPLE_W = 24;
    localparam int FREQ_W   = 18;
    localparam int DAMP_W   = 17;
    localparam int SCALE_W  = 17;
    localparam int STATE_W  = 32;
    localparam int OPA_W    = 19;
    localparam int PROD_W   = 51;
    localparam int SUM_W    = 40;
    localparam int SCALED_W = 28;
    localparam int CLAMP_W  = 26;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    // Output selection codes of the mode register.
    localparam logic [1:0] MODE_LOW   = 2'd0;
    localparam logic [1:0] MODE_BAND  = 2'd1;
    localparam logic [1:0] MODE_HIGH  = 2'd2;
    localparam logic [1:0] MODE_NOTCH = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [FREQ_W-1:0]          freq_coef;
        logic [DAMP_W-1:0]          damp_coef;
        logic [SCALE_W-1:0]         input_scale;
        logic                       voice_start;
    } t_item;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [1:0] {
        MUL_SCALE = 2'd0,
        MUL_FB    = 2'd1,
        MUL_QB    = 2'd2,
        MUL_FH    = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     upd_s;
        logic     upd_low;
        logic     upd_high;
        logic     upd_notch;
        logic     upd_band;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Saturate a wide signed sum to the signed 32-bit range.
    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [STATE_W-1:0] r;
        if (x > 40'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[STATE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/state_variable_filter_2x.sv =====
// ----------------------------------------------------------------------------
// state_variable_filter_2x: double-sampled Chamberlin state variable filter
// Top level joining the sequencer and the datapath to the stream ports and
// the mode register's write channel.
// ----------------------------------------------------------------------------
// Each input word carries one Q1.22 sample together with its own frequency,
// damping and input-gain coefficients, plus a voice-start flag in tuser that
// clears the lowpass, bandpass, highpass and notch state before the sample is
// filtered. The sample is scaled by the input gain and the filter loop is run
// twice on it; the output chosen by the mode register (0 lowpass, 1 bandpass,
// 2 highpass, 3 notch) is clamped to plus or minus one and returned as a Q1.22
// word. One result word follows every input word, in order. A word's result
// reaches the output register after one scaling multiply, five steps for each
// of the two filter passes, and one step to load the result. The block works
// on one word at a time, paced by the single shared 19 by 32 bit multiplier
// with its product register and by the chain of dependences inside each pass.
// The block takes the next input word as soon as the previous result is in
// the output register, even if that result has not yet been taken; only when
// a finished result is still waiting does the block hold its last step until
// the output side frees. The mode register may be written at any time the
// block is idle and is always ready.
// ----------------------------------------------------------------------------
module state_variable_filter_2x
    import svf2x_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input words.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, lowest bit up: sample_in[23:0], freq_coef[41:24], damp_coef[58:42],
    // input_scale[75:59], zero padding[79:76].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: voice_start[0].
    input  logic                  s_axis_tuser,
    // Result words.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, lowest bit up: sample_out[23:0].
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Mode register write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_data
);

    t_item                      w_item;
    t_dp_cmd                    w_cmd;
    t_dp_status                 w_status;
    logic signed [SAMPLE_W-1:0] w_out_data;

    // Unpack the input word into its fields.
    assign w_item.sample_in   = $signed(s_axis_tdata[23:0]);
    assign w_item.freq_coef   = s_axis_tdata[41:24];
    assign w_item.damp_coef   = s_axis_tdata[58:42];
    assign w_item.input_scale = s_axis_tdata[75:59];
    assign w_item.voice_start = s_axis_tuser;

    // The mode register can always be written.
    assign o_cfg_ready = 1'b1;

    svf2x_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    svf2x_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (w_out_data)
    );

    assign m_axis_tdata = w_out_data;

endmodule

// ===== src/svf2x_ctrl.sv =====
// ----------------------------------------------------------------------------
// svf2x_ctrl: filter sequencer
// Steps the datapath through the input scaling and two filter passes, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module svf2x_ctrl
    import svf2x_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MS   = 8'b0000_0010,
        ST_A    = 8'b0000_0100,
        ST_B    = 8'b0000_1000,
        ST_C    = 8'b0001_0000,
        ST_D    = 8'b0010_0000,
        ST_E    = 8'b0100_0000,
        ST_WR   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_SCALE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pass     = 1'b0;
                    n_state    = ST_MS;
                end
            end
            ST_MS: begin
                o_cmd.mul_sel = MUL_SCALE;
                n_state       = ST_A;
            end
            ST_A: begin
                o_cmd.mul_sel = MUL_FB;
                o_cmd.upd_s   = !r_pass;
                n_state       = ST_B;
            end
            ST_B: begin
                o_cmd.mul_sel = MUL_QB;
                o_cmd.upd_low = 1'b1;
                n_state       = ST_C;
            end
            ST_C: begin
                o_cmd.upd_high = 1'b1;
                n_state        = ST_D;
            end
            ST_D: begin
                o_cmd.mul_sel   = MUL_FH;
                o_cmd.upd_notch = 1'b1;
                n_state         = ST_E;
            end
            ST_E: begin
                o_cmd.upd_band = 1'b1;
                if (r_pass) begin
                    n_state = ST_WR;
                end else begin
                    n_pass  = 1'b1;
                    n_state = ST_A;
                end
            end
            ST_WR: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/svf2x_dpath.sv =====
// ----------------------------------------------------------------------------
// svf2x_dpath: filter datapath
// Holds the coefficients, the four filter state values, the shared multiplier
// with its product register, the mode register and the output register.
// ----------------------------------------------------------------------------
module svf2x_dpath
    import svf2x_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_item                      i_item,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic                       i_cfg_valid,
    input  logic [1:0]                 i_cfg_data,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_out_data
);

    logic signed [SAMPLE_W-1:0] r_sample;
    logic [FREQ_W-1:0]          r_f;
    logic [DAMP_W-1:0]          r_q;
    logic [SCALE_W-1:0]         r_scale;
    logic signed [SCALED_W-1:0] r_s;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [STATE_W-1:0]  r_low, r_band, r_high, r_notch;
    logic [1:0]                 r_mode;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic signed [OPA_W-1:0]    w_mul_a;
    logic signed [STATE_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SUM_W-1:0]    w_r16;
    logic signed [SCALED_W-1:0] w_s_round;
    logic signed [STATE_W-1:0]  w_sel;
    logic signed [CLAMP_W-1:0]  w_clamp;
    logic signed [SAMPLE_W-1:0] w_res;

    // Shared multiplier: unsigned coefficient times signed value.
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_SCALE: begin
                w_mul_a = $signed({2'b00, r_scale});
                w_mul_b = STATE_W'(r_sample);
            end
            MUL_FB: begin
                w_mul_a = $signed({1'b0, r_f});
                w_mul_b = r_band;
            end
            MUL_QB: begin
                w_mul_a = $signed({2'b00, r_q});
                w_mul_b = r_band;
            end
            MUL_FH: begin
                w_mul_a = $signed({1'b0, r_f});
                w_mul_b = r_high;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_r16     = SUM_W'((r_prod + 51'sd32768) >>> 16);
    assign w_s_round = SCALED_W'((r_prod + 51'sd8192) >>> 14);

    always_comb begin
        unique case (r_mode)
            MODE_LOW:   w_sel = r_low;
            MODE_BAND:  w_sel = r_band;
            MODE_HIGH:  w_sel = r_high;
            MODE_NOTCH: w_sel = r_notch;
            default:    w_sel = r_notch;
        endcase
        if (w_sel > 32'sd16777216) begin
            w_clamp = 26'sd16777216;
        end else if (w_sel < -32'sd16777216) begin
            w_clamp = -26'sd16777216;
        end else begin
            w_clamp = CLAMP_W'(w_sel);
        end
        w_res = SAMPLE_W'((w_clamp + 26'sd2) >>> 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= '0;
            r_band      <= '0;
            r_high      <= '0;
            r_notch     <= '0;
            r_mode      <= MODE_LOW;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.load && i_item.voice_start) begin
                r_low   <= '0;
                r_band  <= '0;
                r_high  <= '0;
                r_notch <= '0;
            end
            if (i_cmd.upd_low) begin
                r_low <= sat32(SUM_W'(r_low) + w_r16);
            end
            if (i_cmd.upd_high) begin
                r_high <= sat32(SUM_W'(r_s) - SUM_W'(r_low) - w_r16);
            end
            if (i_cmd.upd_notch) begin
                r_notch <= sat32(SUM_W'(r_high) + SUM_W'(r_low));
            end
            if (i_cmd.upd_band) begin
                r_band <= sat32(SUM_W'(r_band) + w_r16);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load) begin
            r_sample <= i_item.sample_in;
            r_f      <= i_item.freq_coef;
            r_q      <= i_item.damp_coef;
            r_scale  <= i_item.input_scale;
        end
        if (i_cmd.upd_s) begin
            r_s <= w_s_round;
        end
        if (i_cmd.out_load) begin
            r_out_data <= w_res;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// ===== dv/state_variable_filter_2x_tb.sv =====
// ----------------------------------------------------------------------------
// state_variable_filter_2x_tb: self-checking bench for the double-sampled SVF
// A short table of directed words is followed by voice-like random runs. Each
// word without a typed result is predicted by a fixed-point model in the bench,
// with idling on both stream sides and mode changes between phases.
// ----------------------------------------------------------------------------
module state_variable_filter_2x_tb
    import svf2x_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 4;
    // Wait after the last result, with margin over the work of one word.
    localparam int SETTLE_CYCLES  = 20;
    localparam int RAND_PER_PHASE = 119;
    localparam int N_PHASES       = 8;
    localparam int DIR_ROWS       = 22;

    localparam int SMP_MAX = 8388607;
    localparam int SMP_MIN = -8388608;
    localparam int ONE_Q16 = 65536;
    localparam int TWO_Q16 = 131072;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_data = MODE_LOW;

    always #5 i_clk = ~i_clk;

    state_variable_filter_2x dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Filter prediction. The four state values are Q8.24 and saturate at the
    // 32-bit limits; every product and the input scaling round to nearest with
    // ties going towards plus infinity.
    // ------------------------------------------------------------------------
    logic signed [STATE_W-1:0] lp_st = '0;
    logic signed [STATE_W-1:0] bp_st = '0;
    logic signed [STATE_W-1:0] hp_st = '0;
    logic signed [STATE_W-1:0] nt_st = '0;
    logic [1:0]                cur_mode = MODE_LOW;

    logic [OUT_DATA_W-1:0] pending_out [$];

    int n_sent     = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_voices   = 0;
    int stall_pct  = 0;
    int send_idle_pct = 0;

    function automatic longint round_shr(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic signed [STATE_W-1:0] clip32(longint x);
        if (x > longint'(32'sh7fff_ffff))
            return 32'sh7fff_ffff;
        if (x < longint'(32'sh8000_0000))
            return 32'sh8000_0000;
        return x[STATE_W-1:0];
    endfunction

    // One trip round the Chamberlin loop on the scaled input s.
    function automatic void svf_pass(longint s, longint f, longint q);
        lp_st = clip32(longint'(lp_st) + round_shr(f * longint'(bp_st), 16));
        hp_st = clip32(s - longint'(lp_st) - round_shr(q * longint'(bp_st), 16));
        bp_st = clip32(longint'(bp_st) + round_shr(f * longint'(hp_st), 16));
        nt_st = clip32(longint'(hp_st) + longint'(lp_st));
    endfunction

    function automatic logic [OUT_DATA_W-1:0] filter_sample(t_item it);
        longint s;
        longint sel;
        longint res;
        if (it.voice_start) begin
            lp_st = '0;
            bp_st = '0;
            hp_st = '0;
            nt_st = '0;
        end
        s = round_shr(longint'($signed(it.sample_in)) * longint'(it.input_scale), 14);
        // The block oversamples by two: the same input goes round twice.
        svf_pass(s, longint'(it.freq_coef), longint'(it.damp_coef));
        svf_pass(s, longint'(it.freq_coef), longint'(it.damp_coef));
        case (cur_mode)
            MODE_LOW:  sel = longint'(lp_st);
            MODE_BAND: sel = longint'(bp_st);
            MODE_HIGH: sel = longint'(hp_st);
            default:   sel = longint'(nt_st);
        endcase
        if (sel > 64'sd16777216)
            sel = 64'sd16777216;
        if (sel < -64'sd16777216)
            sel = -64'sd16777216;
        res = round_shr(sel, 2);
        return res[OUT_DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Driving. A word is offered at a rising edge and accepted at the first
    // later edge that sees tready high; the prediction is made at acceptance.
    // The valid line is only lowered when a gap is taken, so a back-to-back
    // word never sees valid fall and rise in the same step.
    // ------------------------------------------------------------------------
    task automatic send_word(t_item it, bit fixed_exp, logic [OUT_DATA_W-1:0] exp_word);
        logic [OUT_DATA_W-1:0] pred;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.input_scale, it.damp_coef, it.freq_coef, it.sample_in};
        s_axis_tuser  <= it.voice_start;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = filter_sample(it);
        pending_out.push_back(fixed_exp ? exp_word : pred);
        n_sent++;
    endtask

    // The mode register may only change with the filter idle, so every
    // outstanding word is collected first and the pipeline given time to empty.
    task automatic set_mode(logic [1:0] mode);
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    // Random words come mostly as voices: a voice-start word picks a set of
    // coefficients that stays for a run of samples, so the state builds up
    // over many words. The rest is noise with every coefficient field random.
    int          voice_left = 0;
    logic [17:0] v_f;
    logic [16:0] v_q;
    logic [16:0] v_sc;

    function automatic t_item random_item();
        t_item       it;
        logic [31:0] r;
        r = $urandom;
        it.sample_in = r[23:0];
        case ($urandom_range(0, 7))
            0: it.sample_in = SMP_MAX[23:0];
            1: it.sample_in = SMP_MIN[23:0];
            default: ;
        endcase
        if ($urandom_range(0, 99) < 15) begin
            r = $urandom;
            it.freq_coef = r[17:0];
            r = $urandom;
            it.damp_coef = r[16:0];
            r = $urandom;
            it.input_scale = r[16:0];
            it.voice_start = 1'($urandom_range(0, 1));
            return it;
        end
        if (voice_left == 0) begin
            voice_left = $urandom_range(5, 40);
            v_f  = ($urandom_range(0, 3) == 0) ? 18'($urandom_range(0, TWO_Q16))
                                                : 18'($urandom_range(0, 20000));
            v_q  = 17'($urandom_range(0, ONE_Q16));
            v_sc = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, ONE_Q16))
                                                : 17'($urandom_range(16384, ONE_Q16));
            it.voice_start = 1'b1;
            n_voices++;
        end else begin
            it.voice_start = 1'b0;
        end
        voice_left--;
        it.freq_coef   = v_f;
        it.damp_coef   = v_q;
        it.input_scale = v_sc;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Directed words. Rows with a typed result are ones that can be worked out
    // by hand: a cleared filter with zero frequency leaves lowpass and
    // bandpass at zero while highpass and notch follow the scaled input, which
    // at full scale and unit gain clips to plus or minus one.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [1:0] mode;
        bit         vs;
        int         smp;
        int         f;
        int         q;
        int         sc;
        bit         has_exp;
        int         exp_v;
    } t_dir_row;

    t_dir_row dir_tab [DIR_ROWS] = '{
        // Silence straight after reset.
        '{MODE_LOW,   1'b1, 0,       0,       0,       0,       1'b1, 0},
        // Full scale with the loop frozen.
        '{MODE_LOW,   1'b1, SMP_MAX, 0,       0,       ONE_Q16, 1'b1, 0},
        '{MODE_HIGH,  1'b1, SMP_MAX, 0,       0,       ONE_Q16, 1'b1, 4194304},
        '{MODE_HIGH,  1'b1, SMP_MIN, 0,       0,       ONE_Q16, 1'b1, -4194304},
        '{MODE_NOTCH, 1'b1, SMP_MAX, 0,       0,       ONE_Q16, 1'b1, 4194304},
        '{MODE_BAND,  1'b1, SMP_MAX, 0,       0,       ONE_Q16, 1'b1, 0},
        // Top of the nominal coefficient ranges.
        '{MODE_BAND,  1'b1, SMP_MIN, TWO_Q16, ONE_Q16, ONE_Q16, 1'b0, 0},
        '{MODE_BAND,  1'b0, SMP_MAX, TWO_Q16, ONE_Q16, ONE_Q16, 1'b0, 0},
        // An ordinary resonant lowpass settling on a step.
        '{MODE_LOW,   1'b1, 4194304, 8192,    32768,   46341,   1'b0, 0},
        '{MODE_LOW,   1'b0, 4194304, 8192,    32768,   46341,   1'b0, 0},
        '{MODE_LOW,   1'b0, -4194304, 8192,   32768,   46341,   1'b0, 0},
        // Half-way ties in the input scaling, both signs, and an exact product.
        '{MODE_NOTCH, 1'b1, 1,       0,       0,       8192,    1'b0, 0},
        '{MODE_NOTCH, 1'b1, -1,      0,       0,       8192,    1'b0, 0},
        '{MODE_NOTCH, 1'b1, 1,       0,       0,       32768,   1'b0, 0},
        // Coefficients beyond range: the loop runs away and must saturate.
        '{MODE_BAND,  1'b1, SMP_MAX, 262143,  0,       131071,  1'b0, 0},
        '{MODE_BAND,  1'b0, SMP_MAX, 262143,  0,       131071,  1'b0, 0},
        '{MODE_BAND,  1'b0, SMP_MIN, 262143,  0,       131071,  1'b0, 0},
        '{MODE_BAND,  1'b0, SMP_MAX, 262143,  0,       131071,  1'b0, 0},
        '{MODE_LOW,   1'b0, SMP_MIN, 262143,  131071,  131071,  1'b0, 0},
        '{MODE_NOTCH, 1'b0, SMP_MAX, 262143,  131071,  131071,  1'b0, 0},
        '{MODE_HIGH,  1'b0, SMP_MIN, 0,       131071,  131071,  1'b0, 0},
        // A voice start must wipe the saturated state.
        '{MODE_LOW,   1'b1, 0,       0,       0,       0,       1'b1, 0}
    };

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the in-order comparison.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    logic [OUT_DATA_W-1:0] exp_word_q;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected result word %0d, nothing outstanding",
                         $time, $signed(m_axis_tdata));
                n_errors++;
            end else begin
                exp_word_q = pending_out.pop_front();
                n_checked++;
                if (m_axis_tdata !== exp_word_q) begin
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                             $time, $signed(exp_word_q), $signed(m_axis_tdata));
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        t_item it;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, with no idling on either side.
        set_mode(MODE_LOW);
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].mode != cur_mode)
                set_mode(dir_tab[i].mode);
            it.sample_in   = dir_tab[i].smp[23:0];
            it.freq_coef   = dir_tab[i].f[17:0];
            it.damp_coef   = dir_tab[i].q[16:0];
            it.input_scale = dir_tab[i].sc[16:0];
            it.voice_start = dir_tab[i].vs;
            send_word(it, dir_tab[i].has_exp, dir_tab[i].exp_v[23:0]);
        end

        // Random phases: every mode, each under two of the idling patterns.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            set_mode(ph < 4 ? ph[1:0] : 2'(3 - ph + 4));
            for (int k = 0; k < RAND_PER_PHASE; k++)
                send_word(random_item(), 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d random voices) and checked %0d results,",
                 n_sent, n_voices, n_checked);
        $display("over all four output modes and four idling patterns.");
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // The slowest correct run is far below this.
    initial begin
        #5ms;
        $display("Timed out with %0d results outstanding.", pending_out.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
